FILE: rtl/core/rotation_vector_to_quaternion_defines.svh
// Assertion macros shared by the rotation vector to quaternion RTL.
// Each macro expects signals named clock and reset in the including scope.
`ifndef ROTATION_VECTOR_TO_QUATERNION_DEFINES_SVH
`define ROTATION_VECTOR_TO_QUATERNION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RVQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/rvq_pkg.sv
// Shared types, constants and helper functions for the rotation vector to quaternion block.
// No dependencies.
package rvq_pkg;

   localparam int IN_FRAC_DEF  = 27;
   localparam int OUT_FRAC_DEF = 30;

   localparam int              LIMIT_W     = 28;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 28'd13;

   localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
   localparam logic [31:0] HALF_PI_LO     = 32'd2451551556;
   localparam logic [31:0] Q31_ONE        = 32'h8000_0000;

   localparam int SQRT_STEPS   = 32;
   localparam int SERIES_STEPS = 7;
   localparam int DIV_BITS     = 32;
   localparam int DEN_W        = 47;
   localparam int DIV_W        = 79;

   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic [31:0]        phi;
      logic [1:0]         quad;
      logic               flip;
      logic [31:0]        theta;
      logic signed [32:0] sin_v;
      logic signed [32:0] cos_v;
   } side_type;

   function automatic int unsigned sin_denom(input int idx);
      int unsigned d;
      case (idx)
         0: d = 210;
         1: d = 156;
         2: d = 110;
         3: d = 72;
         4: d = 42;
         5: d = 20;
         default: d = 6;
      endcase
      return d;
   endfunction

   function automatic int unsigned cos_denom(input int idx);
      int unsigned d;
      case (idx)
         0: d = 182;
         1: d = 132;
         2: d = 90;
         3: d = 56;
         4: d = 30;
         5: d = 12;
         default: d = 2;
      endcase
      return d;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/rvq_sqrt_cell.sv
// One bit step of the pipelined integer square root.
// Depends on rvq_pkg.
module rvq_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             up_valid,
   input  rvq_pkg::side_type up_side,
   input  logic [63:0]      up_rem,
   input  logic [63:0]      up_res,
   output logic             dn_valid,
   output rvq_pkg::side_type dn_side,
   output logic [63:0]      dn_rem,
   output logic [63:0]      dn_res
);
   import rvq_pkg::*;

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   logic        valid_ff;
   side_type    side_ff;
   logic [63:0] rem_ff, rem_in, res_ff, res_in, trial;

   always_comb begin
      trial = up_res + BIT;
      if (up_rem >= trial) begin
         rem_in = up_rem - trial;
         res_in = (up_res >> 1) + BIT;
      end else begin
         rem_in = up_rem;
         res_in = up_res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
      if (en) begin
         side_ff <= up_side;
         rem_ff  <= rem_in;
         res_ff  <= res_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_rem   = rem_ff;
   assign dn_res   = res_ff;
endmodule

FILE: rtl/core/rvq_series_cell.sv
// One Horner step of the sine and cosine Taylor series, three register stages deep.
// Division by the step's denominator uses a reciprocal multiply with one correction.
// Depends on rvq_pkg.
module rvq_series_cell #(
   parameter int unsigned DS = 6,
   parameter int unsigned DC = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             up_valid,
   input  rvq_pkg::side_type up_side,
   input  logic [31:0]      up_x2,
   input  logic [31:0]      up_acc_s,
   input  logic [31:0]      up_acc_c,
   output logic             dn_valid,
   output rvq_pkg::side_type dn_side,
   output logic [31:0]      dn_x2,
   output logic [31:0]      dn_acc_s,
   output logic [31:0]      dn_acc_c
);
   import rvq_pkg::*;

   localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
   localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);
   localparam logic [31:0] HS = 32'(DS / 2);
   localparam logic [31:0] HC = 32'(DC / 2);

   logic        v1_ff, v2_ff, v3_ff;
   side_type    side1_ff, side2_ff, side3_ff;
   logic [31:0] x2_1_ff, x2_2_ff, x2_3_ff;
   logic [63:0] ps_ff, pc_ff, ms_ff, mc_ff;
   logic [31:0] ns_in, nc_in, ns_ff, nc_ff;
   logic [31:0] qs0, qc0, rs, rc, qs, qc;
   logic [31:0] acc_s_ff, acc_c_ff;

   always_comb begin
      ns_in = 32'((ps_ff + 64'h4000_0000) >> 31) + HS;
      nc_in = 32'((pc_ff + 64'h4000_0000) >> 31) + HC;
      qs0   = ms_ff[63:32];
      qc0   = mc_ff[63:32];
      rs    = ns_ff - 32'(qs0 * DS);
      rc    = nc_ff - 32'(qc0 * DC);
      qs    = (rs >= DS) ? qs0 + 32'd1 : qs0;
      qc    = (rc >= DC) ? qc0 + 32'd1 : qc0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= up_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         side1_ff <= up_side;
         x2_1_ff  <= up_x2;
         ps_ff    <= 64'(up_x2) * 64'(up_acc_s);
         pc_ff    <= 64'(up_x2) * 64'(up_acc_c);
         side2_ff <= side1_ff;
         x2_2_ff  <= x2_1_ff;
         ns_ff    <= ns_in;
         nc_ff    <= nc_in;
         ms_ff    <= 64'(ns_in) * 64'(MS);
         mc_ff    <= 64'(nc_in) * 64'(MC);
         side3_ff <= side2_ff;
         x2_3_ff  <= x2_2_ff;
         acc_s_ff <= Q31_ONE - qs;
         acc_c_ff <= Q31_ONE - qc;
      end
   end

   assign dn_valid = v3_ff;
   assign dn_side  = side3_ff;
   assign dn_x2    = x2_3_ff;
   assign dn_acc_s = acc_s_ff;
   assign dn_acc_c = acc_c_ff;
endmodule

FILE: rtl/core/rvq_div_cell.sv
// One quotient bit of the three-lane restoring divider that scales the vector parts.
// Depends on rvq_pkg.
module rvq_div_cell #(
   parameter int SHIFT = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        up_valid,
   input  rvq_pkg::side_type           up_side,
   input  logic [rvq_pkg::DEN_W-1:0]   up_den,
   input  logic [rvq_pkg::DIV_W-1:0]   up_rem [3],
   input  logic [rvq_pkg::DIV_BITS-1:0] up_quo [3],
   output logic                        dn_valid,
   output rvq_pkg::side_type           dn_side,
   output logic [rvq_pkg::DEN_W-1:0]   dn_den,
   output logic [rvq_pkg::DIV_W-1:0]   dn_rem [3],
   output logic [rvq_pkg::DIV_BITS-1:0] dn_quo [3]
);
   import rvq_pkg::*;

   logic                valid_ff;
   side_type            side_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [DIV_W-1:0]    dsh;
   logic [DIV_W-1:0]    rem_in [3];
   logic [DIV_W-1:0]    rem_ff [3];
   logic [DIV_BITS-1:0] quo_in [3];
   logic [DIV_BITS-1:0] quo_ff [3];

   always_comb begin
      dsh = DIV_W'(up_den) << SHIFT;
      for (int i = 0; i < 3; i++) begin
         if (up_rem[i] >= dsh) begin
            rem_in[i] = up_rem[i] - dsh;
            quo_in[i] = {up_quo[i][DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in[i] = up_rem[i];
            quo_in[i] = {up_quo[i][DIV_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
      if (en) begin
         side_ff <= up_side;
         den_ff  <= up_den;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_den   = den_ff;
   assign dn_rem   = rem_ff;
   assign dn_quo   = quo_ff;
endmodule

FILE: rtl/core/rotation_vector_to_quaternion.sv
// Rotation vector to unit quaternion, fully pipelined: one transfer accepted every cycle while
// the output is not stalled. Pipeline stages: 2 for the squares and sum, 32 square root cells,
// 6 for angle reduction, 21 series stages, 4 for sine selection and the divider setup, 32
// divider cells and the output register. A stalled output holds the whole chain.
// Synchronous active-high reset clears all valid bits and loads the small-angle limit with 13.
// Depends on rvq_pkg, rvq_sqrt_cell, rvq_series_cell, rvq_div_cell and the defines header.
module rotation_vector_to_quaternion #(
   parameter int INPUT_FRAC_BITS  = rvq_pkg::IN_FRAC_DEF,
   parameter int OUTPUT_FRAC_BITS = rvq_pkg::OUT_FRAC_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [rvq_pkg::LIMIT_W-1:0] csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [31:0]          req_rot_x,
   input  logic signed [31:0]          req_rot_y,
   input  logic signed [31:0]          req_rot_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_quat_w,
   output logic signed [31:0]          rsp_quat_x,
   output logic signed [31:0]          rsp_quat_y,
   output logic signed [31:0]          rsp_quat_z
);
   import rvq_pkg::*;
`include "rotation_vector_to_quaternion_defines.svh"

   localparam int TURN_SHIFT  = INPUT_FRAC_BITS + 33;
   localparam int OUT_SHIFT   = 31 - OUTPUT_FRAC_BITS;
   localparam int SMALL_SHIFT = OUTPUT_FRAC_BITS - INPUT_FRAC_BITS - 1;
   localparam int SL          = (SMALL_SHIFT > 0) ? SMALL_SHIFT : 0;
   localparam int SR          = (SMALL_SHIFT < 0) ? -SMALL_SHIFT : 0;
   localparam logic signed [63:0] SMALL_RND = (64'sd1 <<< SR) >>> 1;
   localparam logic signed [63:0] W_RND     = 64'sd1 <<< (OUT_SHIFT - 1);
   localparam logic signed [63:0] W_ONE     = 64'sd1 <<< OUTPUT_FRAC_BITS;
   localparam logic [31:0]        QUO_MAX   = (32'd1 << OUTPUT_FRAC_BITS) + 32'd1;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic [31:0] mag33(input logic signed [32:0] v);
      return v[32] ? 32'(-v) : 32'(v);
   endfunction

   logic en;
   logic rsp_valid_ff;
   logic [LIMIT_W-1:0] limit_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // Squares and their sum.
   side_type    a_side_in, a_side_ff, b_side_ff;
   logic        a_valid_ff, b_valid_ff;
   logic [63:0] a_sq_ff [3];
   logic [63:0] b_sum_ff;

   always_comb begin
      a_side_in    = '0;
      a_side_in.vx = req_rot_x;
      a_side_in.vy = req_rot_y;
      a_side_in.vz = req_rot_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         a_side_ff  <= a_side_in;
         a_sq_ff[0] <= 64'(mag32(req_rot_x)) * 64'(mag32(req_rot_x));
         a_sq_ff[1] <= 64'(mag32(req_rot_y)) * 64'(mag32(req_rot_y));
         a_sq_ff[2] <= 64'(mag32(req_rot_z)) * 64'(mag32(req_rot_z));
         b_side_ff  <= a_side_ff;
         b_sum_ff   <= a_sq_ff[0] + a_sq_ff[1] + a_sq_ff[2];
      end
   end

   // Square root chain.
   logic        sq_valid [SQRT_STEPS+1];
   side_type    sq_side  [SQRT_STEPS+1];
   logic [63:0] sq_rem   [SQRT_STEPS+1];
   logic [63:0] sq_res   [SQRT_STEPS+1];

   assign sq_valid[0] = b_valid_ff;
   assign sq_side[0]  = b_side_ff;
   assign sq_rem[0]   = b_sum_ff;
   assign sq_res[0]   = 64'd0;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      rvq_sqrt_cell #(.STEP(k)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .up_valid(sq_valid[k]), .up_side(sq_side[k]),
         .up_rem(sq_rem[k]), .up_res(sq_res[k]),
         .dn_valid(sq_valid[k+1]), .dn_side(sq_side[k+1]),
         .dn_rem(sq_rem[k+1]), .dn_res(sq_res[k+1])
      );
   end

   // Angle reduction to a fraction of a turn, then to a Q31 octant angle.
   side_type    t1_side_in, t1_side_ff, t2_side_ff, r1_side_in, r1_side_ff;
   side_type    r2_side_in, r2_side_ff, r3_side_ff, r4_side_ff;
   logic        t1_valid_ff, t2_valid_ff, r1_valid_ff, r2_valid_ff, r3_valid_ff, r4_valid_ff;
   logic [63:0] t1_lo_ff, t1_hi_ff;
   logic [95:0] t2_full;
   logic [31:0] t2_turn_ff;
   logic [29:0] r1_frac;
   logic [30:0] r1_rr_in, r1_rr_ff;
   logic [62:0] r1_prod_ff;
   logic [31:0] r2_theta_in, r2_theta_ff;
   logic [63:0] r3_sq_ff;
   logic [31:0] r4_x2_ff;

   always_comb begin
      t1_side_in     = sq_side[SQRT_STEPS];
      t1_side_in.phi = sq_res[SQRT_STEPS][31:0];
      t2_full        = 96'(t1_lo_ff) + (96'(t1_hi_ff) << 32);
      r1_frac        = t2_turn_ff[29:0];
      r1_side_in      = t2_side_ff;
      r1_side_in.quad = t2_turn_ff[31:30];
      r1_side_in.flip = t2_turn_ff[29];
      r1_rr_in = t2_turn_ff[29] ? 31'(31'h4000_0000 - {1'b0, r1_frac}) : {1'b0, r1_frac};
      r2_theta_in = 32'((64'(r1_prod_ff) + (64'(r1_rr_ff) << 32) + 64'h4000_0000) >> 31);
      r2_side_in       = r1_side_ff;
      r2_side_in.theta = r2_theta_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         r1_valid_ff <= 1'b0;
         r2_valid_ff <= 1'b0;
         r3_valid_ff <= 1'b0;
         r4_valid_ff <= 1'b0;
      end else if (en) begin
         t1_valid_ff <= sq_valid[SQRT_STEPS];
         t2_valid_ff <= t1_valid_ff;
         r1_valid_ff <= t2_valid_ff;
         r2_valid_ff <= r1_valid_ff;
         r3_valid_ff <= r2_valid_ff;
         r4_valid_ff <= r3_valid_ff;
      end
      if (en) begin
         t1_side_ff  <= t1_side_in;
         t1_lo_ff    <= 64'(t1_side_in.phi) * 64'(INV_TWO_PI_Q64[31:0]);
         t1_hi_ff    <= 64'(t1_side_in.phi) * 64'(INV_TWO_PI_Q64[63:32]);
         t2_side_ff  <= t1_side_ff;
         t2_turn_ff  <= t2_full[TURN_SHIFT +: 32];
         r1_side_ff  <= r1_side_in;
         r1_rr_ff    <= r1_rr_in;
         r1_prod_ff  <= 63'(r1_rr_in) * 63'(HALF_PI_LO);
         r2_side_ff  <= r2_side_in;
         r2_theta_ff <= r2_theta_in;
         r3_side_ff  <= r2_side_ff;
         r3_sq_ff    <= 64'(r2_theta_ff) * 64'(r2_theta_ff);
         r4_side_ff  <= r3_side_ff;
         r4_x2_ff    <= 32'((r3_sq_ff + 64'h4000_0000) >> 31);
      end
   end

   // Sine and cosine series chain.
   logic        se_valid [SERIES_STEPS+1];
   side_type    se_side  [SERIES_STEPS+1];
   logic [31:0] se_x2    [SERIES_STEPS+1];
   logic [31:0] se_acc_s [SERIES_STEPS+1];
   logic [31:0] se_acc_c [SERIES_STEPS+1];

   assign se_valid[0] = r4_valid_ff;
   assign se_side[0]  = r4_side_ff;
   assign se_x2[0]    = r4_x2_ff;
   assign se_acc_s[0] = Q31_ONE;
   assign se_acc_c[0] = Q31_ONE;

   for (genvar k = 0; k < SERIES_STEPS; k++) begin : g_series
      rvq_series_cell #(.DS(sin_denom(k)), .DC(cos_denom(k))) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .up_valid(se_valid[k]), .up_side(se_side[k]), .up_x2(se_x2[k]),
         .up_acc_s(se_acc_s[k]), .up_acc_c(se_acc_c[k]),
         .dn_valid(se_valid[k+1]), .dn_side(se_side[k+1]), .dn_x2(se_x2[k+1]),
         .dn_acc_s(se_acc_s[k+1]), .dn_acc_c(se_acc_c[k+1])
      );
   end

   // Quadrant unfolding and divider setup.
   side_type           f1_side_ff, f2_side_in, f2_side_ff, d0_side_ff, d1_side_ff;
   logic               f1_valid_ff, f2_valid_ff, d0_valid_ff, d1_valid_ff;
   logic [63:0]        f1_sp_ff;
   logic [31:0]        f1_pc_ff;
   logic signed [32:0] ps, pc, sa, ca;
   logic [31:0]        s_mag;
   logic [63:0]        d0_num_ff [3];
   logic [DEN_W-1:0]   d0_den_ff, d1_den_ff;
   logic [DIV_W-1:0]   d1_rem_ff [3];

   always_comb begin
      ps = signed'({1'b0, 32'((f1_sp_ff + 64'h4000_0000) >> 31)});
      pc = signed'({1'b0, f1_pc_ff});
      sa = f1_side_ff.flip ? pc : ps;
      ca = f1_side_ff.flip ? ps : pc;
      f2_side_in = f1_side_ff;
      case (f1_side_ff.quad)
         QUAD_0: begin
            f2_side_in.sin_v = sa;
            f2_side_in.cos_v = ca;
         end
         QUAD_1: begin
            f2_side_in.sin_v = ca;
            f2_side_in.cos_v = -sa;
         end
         QUAD_2: begin
            f2_side_in.sin_v = -sa;
            f2_side_in.cos_v = -ca;
         end
         default: begin
            f2_side_in.sin_v = -ca;
            f2_side_in.cos_v = sa;
         end
      endcase
      s_mag = mag33(f2_side_ff.sin_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         d0_valid_ff <= 1'b0;
         d1_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= se_valid[SERIES_STEPS];
         f2_valid_ff <= f1_valid_ff;
         d0_valid_ff <= f2_valid_ff;
         d1_valid_ff <= d0_valid_ff;
      end
      if (en) begin
         f1_side_ff   <= se_side[SERIES_STEPS];
         f1_sp_ff     <= 64'(se_side[SERIES_STEPS].theta) * 64'(se_acc_s[SERIES_STEPS]);
         f1_pc_ff     <= se_acc_c[SERIES_STEPS];
         f2_side_ff   <= f2_side_in;
         d0_side_ff   <= f2_side_ff;
         d0_num_ff[0] <= 64'(mag32(f2_side_ff.vx)) * 64'(s_mag);
         d0_num_ff[1] <= 64'(mag32(f2_side_ff.vy)) * 64'(s_mag);
         d0_num_ff[2] <= 64'(mag32(f2_side_ff.vz)) * 64'(s_mag);
         d0_den_ff    <= DEN_W'(f2_side_ff.phi) << OUT_SHIFT;
         d1_side_ff   <= d0_side_ff;
         d1_den_ff    <= d0_den_ff;
         for (int i = 0; i < 3; i++) begin
            d1_rem_ff[i] <= DIV_W'(d0_num_ff[i]) + DIV_W'(d0_den_ff >> 1);
         end
      end
   end

   // Divider chain.
   logic                dv_valid [DIV_BITS+1];
   side_type            dv_side  [DIV_BITS+1];
   logic [DEN_W-1:0]    dv_den   [DIV_BITS+1];
   logic [DIV_W-1:0]    dv_rem   [DIV_BITS+1][3];
   logic [DIV_BITS-1:0] dv_quo   [DIV_BITS+1][3];

   assign dv_valid[0] = d1_valid_ff;
   assign dv_side[0]  = d1_side_ff;
   assign dv_den[0]   = d1_den_ff;
   assign dv_rem[0]   = d1_rem_ff;
   for (genvar i = 0; i < 3; i++) begin : g_quo0
      assign dv_quo[0][i] = '0;
   end

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      rvq_div_cell #(.SHIFT(DIV_BITS - 1 - k)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .up_valid(dv_valid[k]), .up_side(dv_side[k]), .up_den(dv_den[k]),
         .up_rem(dv_rem[k]), .up_quo(dv_quo[k]),
         .dn_valid(dv_valid[k+1]), .dn_side(dv_side[k+1]), .dn_den(dv_den[k+1]),
         .dn_rem(dv_rem[k+1]), .dn_quo(dv_quo[k+1])
      );
   end

   // Output selection and register.
   side_type           o_side;
   logic               small_path;
   logic signed [63:0] v_ext [3];
   logic signed [63:0] c_ext, w_big, part;
   logic signed [31:0] q_in [4];
   logic signed [31:0] q_ff [4];

   always_comb begin
      o_side     = dv_side[DIV_BITS];
      small_path = (o_side.phi == 32'd0) || (o_side.phi < 32'(limit_ff));
      v_ext[0]   = 64'(o_side.vx);
      v_ext[1]   = 64'(o_side.vy);
      v_ext[2]   = 64'(o_side.vz);
      c_ext      = 64'(o_side.cos_v);
      w_big      = (c_ext + W_RND) >>> OUT_SHIFT;
      q_in[0]    = small_path ? sat32(W_ONE) : sat32(w_big);
      for (int i = 0; i < 3; i++) begin
         if (small_path) begin
            part = ((v_ext[i] + SMALL_RND) >>> SR) <<< SL;
         end else if (v_ext[i][63] ^ o_side.sin_v[32]) begin
            part = -signed'({32'd0, dv_quo[DIV_BITS][i]});
         end else begin
            part = signed'({32'd0, dv_quo[DIV_BITS][i]});
         end
         q_in[i+1] = sat32(part);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid[DIV_BITS];
      end
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_w = q_ff[0];
   assign rsp_quat_x = q_ff[1];
   assign rsp_quat_y = q_ff[2];
   assign rsp_quat_z = q_ff[3];

   `RVQ_ASSERT_NOW(a_sqrt_fits, sq_valid[SQRT_STEPS], sq_res[SQRT_STEPS][63:32] == 32'd0, "square root exceeds 32 bits")
   `RVQ_ASSERT_NOW(a_series_bound, se_valid[SERIES_STEPS], (se_acc_s[SERIES_STEPS] <= Q31_ONE) && (se_acc_c[SERIES_STEPS] <= Q31_ONE), "series result above one")
   `RVQ_ASSERT_NOW(a_quo_bound, dv_valid[DIV_BITS] && !small_path, (dv_quo[DIV_BITS][0] <= QUO_MAX) && (dv_quo[DIV_BITS][1] <= QUO_MAX) && (dv_quo[DIV_BITS][2] <= QUO_MAX), "scaled part above one")
   `RVQ_ASSERT_NEXT(a_w_bound, en && dv_valid[DIV_BITS], (64'(rsp_quat_w) <= W_ONE) && (64'(rsp_quat_w) >= -W_ONE), "quaternion scalar out of range")
endmodule

FILE: dv/rvq_checker.sv
`timescale 1ns / 1ps
// Checker for the rotation vector to quaternion block: watches both channels and the csr port,
// predicts each quaternion from the accepted rotation vector and compares all four fields at once.
// Depends on rvq_pkg for the limit width and the 1/(2 pi) constant.
module rvq_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [rvq_pkg::LIMIT_W-1:0] csr_wr_data,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic signed [31:0]          req_rot_x,
   input  logic signed [31:0]          req_rot_y,
   input  logic signed [31:0]          req_rot_z,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic signed [31:0]          rsp_quat_w,
   input  logic signed [31:0]          rsp_quat_x,
   input  logic signed [31:0]          rsp_quat_y,
   input  logic signed [31:0]          rsp_quat_z,
   output int                          errors,
   output int                          pending
);

   typedef struct packed {
      logic signed [31:0] w;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } quat_type;

   localparam longint unsigned HALF_PI_Q32 = 64'd6746518852;
   localparam longint unsigned ONE_Q31     = 64'h8000_0000;

   quat_type                    quat_queue[$];
   logic [rvq_pkg::LIMIT_W-1:0] angle_limit;

   function automatic logic [31:0] root_of(input longint unsigned n);
      longint unsigned res;
      longint unsigned bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res[31:0];
   endfunction

   function automatic longint unsigned mul_q31(input longint unsigned a, input longint unsigned b);
      return (a * b + (64'd1 << 30)) >> 31;
   endfunction

   function automatic longint unsigned taylor(input longint unsigned x2, input logic is_cos);
      int unsigned     sin_d[7];
      int unsigned     cos_d[7];
      longint unsigned acc;
      longint unsigned d;
      sin_d = '{210, 156, 110, 72, 42, 20, 6};
      cos_d = '{182, 132, 90, 56, 30, 12, 2};
      acc = ONE_Q31;
      for (int i = 0; i < 7; i++) begin
         d = is_cos ? cos_d[i] : sin_d[i];
         acc = ONE_Q31 - (mul_q31(x2, acc) + d / 2) / d;
      end
      return acc;
   endfunction

   function automatic longint shr_round(input longint v, input int k);
      longint unsigned b;
      b = v + (64'sd1 << 48);
      return longint'((b + (64'd1 << (k - 1))) >> k) - (64'sd1 << (48 - k));
   endfunction

   function automatic logic signed [31:0] sat_word(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic quat_type exp_map(input logic signed [31:0] rx,
                                        input logic signed [31:0] ry,
                                        input logic signed [31:0] rz);
      longint          comp[3];
      longint unsigned sum, plo, phi_hi, low, high, r, rr, theta, x2, den, num, q;
      longint          ps, pc, sa, ca, s, c;
      logic [31:0]     phi, turn;
      logic            flip, neg;
      quat_type        res;
      longint          parts[3];
      comp[0] = rx;
      comp[1] = ry;
      comp[2] = rz;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         num = comp[i] < 0 ? -comp[i] : comp[i];
         sum = sum + num * num;
      end
      phi = root_of(sum);
      if (phi == 0 || phi < angle_limit) begin
         res.w = sat_word(64'sd1 << 30);
         for (int i = 0; i < 3; i++) parts[i] = comp[i] * 4;
      end else begin
         plo = longint'(phi) * rvq_pkg::INV_TWO_PI_Q64[31:0];
         phi_hi = longint'(phi) * rvq_pkg::INV_TWO_PI_Q64[63:32];
         low = plo + (phi_hi << 32);
         high = (phi_hi >> 32) + ((low < plo) ? 1 : 0);
         turn = 32'((low >> 60) | (high << 4));
         r = turn & 32'h3FFF_FFFF;
         flip = r >= (64'd1 << 29);
         rr = flip ? (64'd1 << 30) - r : r;
         theta = (rr * HALF_PI_Q32 + (64'd1 << 30)) >> 31;
         x2 = mul_q31(theta, theta);
         ps = mul_q31(theta, taylor(x2, 1'b0));
         pc = taylor(x2, 1'b1);
         sa = flip ? pc : ps;
         ca = flip ? ps : pc;
         case (turn[31:30])
            2'd0: begin s = sa; c = ca; end
            2'd1: begin s = ca; c = -sa; end
            2'd2: begin s = -sa; c = -ca; end
            default: begin s = -ca; c = sa; end
         endcase
         res.w = sat_word(shr_round(c, 1));
         den = longint'(phi) << 1;
         for (int i = 0; i < 3; i++) begin
            num = (comp[i] < 0 ? -comp[i] : comp[i]) * (s < 0 ? -s : s);
            q = (num + den / 2) / den;
            neg = (comp[i] < 0) != (s < 0);
            parts[i] = neg ? -longint'(q) : longint'(q);
         end
      end
      res.x = sat_word(parts[0]);
      res.y = sat_word(parts[1]);
      res.z = sat_word(parts[2]);
      return res;
   endfunction

   assign pending = quat_queue.size();

   always @(posedge clock) begin
      quat_type expd;
      if (reset) begin
         quat_queue.delete();
         angle_limit <= 28'd13;
         errors = 0;
      end else begin
         if (csr_wr_en) angle_limit <= csr_wr_data;
         if (req_valid && !req_stall) quat_queue.push_back(exp_map(req_rot_x, req_rot_y, req_rot_z));
         if (rsp_valid && !rsp_stall) begin
            if (quat_queue.size() == 0) begin
               $display("%0t: unexpected transfer w=%h x=%h y=%h z=%h", $time,
                        rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
               errors++;
            end else begin
               expd = quat_queue.pop_front();
               if (expd != {rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z}) begin
                  $display("%0t: expected w=%h x=%h y=%h z=%h got w=%h x=%h y=%h z=%h", $time,
                           expd.w, expd.x, expd.y, expd.z,
                           rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
                  errors++;
               end
            end
         end
      end
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the rotation vector to quaternion testbench: clock, reset, stimulus and verdict.
// Depends on rvq_pkg, the block and rvq_checker.
module tb_top;

   localparam int CYCLE_LIMIT = 2000000;

   logic                        clock;
   logic                        reset;
   logic                        csr_wr_en;
   logic [rvq_pkg::LIMIT_W-1:0] csr_wr_data;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [31:0]          req_rot_x, req_rot_y, req_rot_z;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [31:0]          rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   int                          errors, pending;
   int                          cycles = 0;
   int                          stall_left = 0;
   logic                        quiet;

   rotation_vector_to_quaternion dut (.*);
   rvq_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_vector(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rot_x <= x;
      req_rot_y <= y;
      req_rot_z <= z;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic set_limit(input logic [rvq_pkg::LIMIT_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_component(input logic [27:0] lim);
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 3))
         0: return v;
         1: return $signed(v) >>> $urandom_range(0, 31);
         2: return $signed(v) >>> 2;
         default: return ($urandom_range(0, 1) ? lim : -lim) + $signed($urandom_range(0, 8)) - 4;
      endcase
   endfunction

   task automatic random_items(input int count, input logic [27:0] lim);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_vector(($urandom_range(0, 1) ? lim : 0) + $urandom_range(0, 2) - 1, 0, 0);
         else
            send_vector(pick_component(lim), pick_component(lim), pick_component(lim));
      end
   endtask

   initial begin
      logic [27:0] lim;
      reset = 1'b1;
      quiet = 1'b0;
      req_valid = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_rot_x = 0;
      req_rot_y = 0;
      req_rot_z = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_vector(0, 0, 0);
      send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h8000_0000, 0, 0);
      send_vector(0, 32'h7FFF_FFFF, 0);
      send_vector(0, 0, -1);
      send_vector(12, 0, 0);
      send_vector(13, 0, 0);
      send_vector(0, -14, 0);
      send_vector(32'd421657428, 0, 0);
      send_vector(0, 32'd843314857, 0);
      send_vector(0, 0, -32'sd210828714);
      send_vector(32'd134217728, -32'sd134217728, 32'd134217728);
      send_vector(-1, 1, -1);

      set_limit(0);
      send_vector(0, 0, 0);
      send_vector(1, 0, 0);
      send_vector(0, -1, 3);
      random_items(300, 1);

      set_limit(28'd134217728);
      send_vector(32'd134217727, 0, 0);
      send_vector(32'd134217728, 0, 0);
      send_vector(32'h7FFF_FFFF, 32'h8000_0000, 5);
      random_items(300, 28'd134217728);

      set_limit(28'hFFF_FFFF);
      send_vector(32'h0FFF_FFFE, 0, 0);
      send_vector(32'h0FFF_FFFF, 0, 0);
      random_items(200, 28'hFFF_FFFF);

      lim = 28'($urandom_range(1, 4000));
      set_limit(lim);
      random_items(200, lim);
      quiet = 1'b1;
      random_items(200, lim);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
